// ===== rtl/core/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, register indexes and request types.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegOversampling = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefAc123 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefAc456 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefB12 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefMcmd = 3'd4;

  localparam logic CmdTemp = 1'b0;
  localparam logic CmdPress = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [23:0] raw_reading;
  } in_req_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] temperature_tenths;
    logic        [17:0] pressure_pa;
    logic               divide_error;
  } out_req_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_cmd_t;

endpackage

// ===== rtl/core/bsc_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one request of a given payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface bsc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bsc_div.sv =====
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsc_pkg::div_cmd_t cmd_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);

  logic [31:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[31]} - {1'b0, dvs_q};
    if (cmd_i.start) begin
      quot_d = cmd_i.dividend;
      rem_d  = '0;
      dvs_d  = cmd_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
      end else begin
        rem_d = {rem_q[30:0], quot_q[31]};
      end
      quot_d = {quot_q[30:0], !trial[32]};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/bsc_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product modulo 2^32, four multiplier bits per cycle.
// ----------------------------------------------------------------------------
module bsc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] prod_o
);

  logic [31:0] acc_q, acc_d;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [35:0] part;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    part   = {4'd0, a_q} * {32'd0, b_q[3:0]};
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + part[31:0];
      a_d   = {a_q[27:0], 4'd0};
      b_d   = {4'd0, b_q[31:4]};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Applies the integer temperature and pressure compensation to raw readings.
// ----------------------------------------------------------------------------
// Usage: configuration requests on cfg carry a register index and write data;
// index 0 sets the oversampling, 1 to 4 the packed calibration words. Writes
// are taken only while no reading is in progress and no result waits.
// A request on the input channel carries cmd and the raw reading. A
// temperature request stores B5 for later pressure requests; a pressure
// request uses the stored B5. Each request gives exactly one result request.
// When a divisor is zero the divide is skipped and the result carries
// divide_error. A shared 4-bit-per-cycle multiplier forms the products and a
// 1-bit-per-cycle divider the quotients. One request is worked on at a time;
// the next request is taken once the previous result has moved into the output
// register, also while that result still waits there. A finished result is
// held in its last state until the output register is free.
// Reset clears the calibration registers and B5 to zero and empties the
// output register.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsc_if.sink   cfg,
  bsc_if.sink   in_req,
  bsc_if.source out_req
);

  typedef enum logic [4:0] {
    StIdle, StT1, StT2, StT3, StT4, StTDone,
    StP1, StP2, StP3, StP4, StP5, StP6, StP7, StP8, StP9, StP10,
    StP11, StP12, StP13, StP14, StP15, StPDone, StOut
  } state_e;

  state_e state_q;

  logic [1:0]  oss_q;
  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b12_q, mcmd_q, b5_q;
  logic [23:0] raw_q;
  logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  logic        ovalid_q;
  bsc_pkg::out_req_t obuf_q;
  bsc_pkg::out_req_t res_q;
  logic        load_out;

  logic        mstart_q, mdone;
  logic [31:0] ma_q, mb_q, mprod;
  bsc_pkg::div_cmd_t dcmd_q;
  logic        ddone;
  logic [31:0] dquot;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] neg_if(input logic [31:0] x, input logic c);
    return c ? 32'd0 - x : x;
  endfunction

  bsc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart_q), .a_i(ma_q), .b_i(mb_q),
    .done_o(mdone), .prod_o(mprod)
  );

  bsc_div u_div (
    .clk_i, .rst_ni, .cmd_i(dcmd_q), .done_o(ddone), .quot_o(dquot)
  );

  assign load_out = (state_q inside {StTDone, StPDone, StOut}) &&
                    (!ovalid_q || out_req.ready);

  assign cfg.ready     = (state_q == StIdle) && !ovalid_q;
  assign in_req.ready  = (state_q == StIdle);
  assign out_req.valid = ovalid_q;
  assign out_req.payload = obuf_q;

  logic [31:0] t_tmp, den_tmp, b3_tmp, x3_tmp, p_tmp, r_tmp, up_tmp;

  always_comb begin
    den_tmp = r0_q + sx16(mcmd_q[15:0]);
    t_tmp   = asr(b5_q + 32'd8, 5'd4);
    x3_tmp  = r2_q + r3_q;
    b3_tmp  = asr(((sx16(ac123_q[47:32]) << 2) + x3_tmp << oss_q) + 32'd2, 5'd2);
    up_tmp  = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
    p_tmp   = r1_q[31] ? {dquot[30:0], 1'b0} : dquot;
    r_tmp   = r3_q + asr(r0_q + r2_q + 32'd3791, 5'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      oss_q    <= '0;
      ac123_q  <= '0;
      ac456_q  <= '0;
      b12_q    <= '0;
      mcmd_q   <= '0;
      b5_q     <= '0;
      ovalid_q <= 1'b0;
      mstart_q <= 1'b0;
      dcmd_q   <= '0;
    end else begin
      mstart_q     <= 1'b0;
      dcmd_q.start <= 1'b0;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_req.valid && out_req.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cfg.valid && cfg.ready) begin
            unique case (cfg.payload.index)
              bsc_pkg::RegOversampling: oss_q <= cfg.payload.data[1:0];
              bsc_pkg::RegCoefAc123:    ac123_q <= cfg.payload.data;
              bsc_pkg::RegCoefAc456:    ac456_q <= cfg.payload.data;
              bsc_pkg::RegCoefB12:      b12_q <= cfg.payload.data[31:0];
              bsc_pkg::RegCoefMcmd:     mcmd_q <= cfg.payload.data[31:0];
              default: ;
            endcase
          end
          if (in_req.valid && in_req.ready) begin
            raw_q    <= in_req.payload.raw_reading;
            mstart_q <= 1'b1;
            if (in_req.payload.cmd == bsc_pkg::CmdTemp) begin
              ma_q    <= {16'd0, in_req.payload.raw_reading[15:0]} -
                         {16'd0, ac456_q[15:0]};
              mb_q    <= {16'd0, ac456_q[31:16]};
              state_q <= StT1;
            end else begin
              ma_q    <= b5_q - 32'd4000;
              mb_q    <= b5_q - 32'd4000;
              r4_q    <= b5_q - 32'd4000;
              state_q <= StP1;
            end
          end
        end
        StT1: if (mdone) begin
          r0_q    <= asr(mprod, 5'd15);
          state_q <= StT2;
        end
        StT2: begin
          if (den_tmp == '0) begin
            res_q   <= '{kind: bsc_pkg::CmdTemp, temperature_tenths: '0,
                         pressure_pa: '0, divide_error: 1'b1};
            state_q <= StOut;
          end else begin
            dcmd_q  <= '{start: 1'b1,
                         dividend: neg_if(sx16(mcmd_q[31:16]) << 11, mcmd_q[31]),
                         divisor: neg_if(den_tmp, den_tmp[31])};
            r1_q    <= {31'd0, mcmd_q[31] ^ den_tmp[31]};
            state_q <= StT3;
          end
        end
        StT3: if (ddone) begin
          b5_q    <= r0_q + neg_if(dquot, r1_q[0]);
          state_q <= StT4;
        end
        StT4: begin
          if (t_tmp[31]) begin
            res_q.temperature_tenths <= (t_tmp < 32'hFFFF8000) ? 16'sh8000
                                        : t_tmp[15:0];
          end else begin
            res_q.temperature_tenths <= (t_tmp > 32'd32767) ? 16'sh7FFF
                                        : t_tmp[15:0];
          end
          res_q.kind         <= bsc_pkg::CmdTemp;
          res_q.pressure_pa  <= '0;
          res_q.divide_error <= 1'b0;
          state_q <= StTDone;
        end
        StP1: if (mdone) begin
          r0_q     <= asr(mprod, 5'd12);
          ma_q     <= sx16(b12_q[15:0]);
          mb_q     <= asr(mprod, 5'd12);
          mstart_q <= 1'b1;
          state_q  <= StP2;
        end
        StP2: if (mdone) begin
          r2_q     <= asr(mprod, 5'd11);
          ma_q     <= sx16(ac123_q[31:16]);
          mb_q     <= r4_q;
          mstart_q <= 1'b1;
          state_q  <= StP3;
        end
        StP3: if (mdone) begin
          r3_q     <= asr(mprod, 5'd11);
          ma_q     <= sx16(ac123_q[15:0]);
          mb_q     <= r4_q;
          mstart_q <= 1'b1;
          state_q  <= StP4;
        end
        StP4: if (mdone) begin
          r1_q     <= b3_tmp;
          r2_q     <= asr(mprod, 5'd13);
          ma_q     <= sx16(b12_q[31:16]);
          mb_q     <= r0_q;
          mstart_q <= 1'b1;
          state_q  <= StP5;
        end
        StP5: if (mdone) begin
          ma_q     <= {16'd0, ac456_q[47:32]};
          mb_q     <= asr(r2_q + asr(mprod, 5'd16) + 32'd2, 5'd2) + 32'd32768;
          mstart_q <= 1'b1;
          state_q  <= StP6;
        end
        StP6: if (mdone) begin
          r4_q     <= mprod >> 15;
          ma_q     <= up_tmp - r1_q;
          mb_q     <= 32'd50000 >> oss_q;
          mstart_q <= 1'b1;
          state_q  <= StP7;
        end
        StP7: if (mdone) begin
          if (r4_q == '0) begin
            res_q   <= '{kind: bsc_pkg::CmdPress, temperature_tenths: '0,
                         pressure_pa: '0, divide_error: 1'b1};
            state_q <= StOut;
          end else begin
            r1_q    <= mprod;
            dcmd_q  <= '{start: 1'b1,
                         dividend: mprod[31] ? mprod : {mprod[30:0], 1'b0},
                         divisor: r4_q};
            state_q <= StP8;
          end
        end
        StP8: if (ddone) begin
          r3_q     <= p_tmp;
          ma_q     <= asr(p_tmp, 5'd8);
          mb_q     <= asr(p_tmp, 5'd8);
          mstart_q <= 1'b1;
          state_q  <= StP9;
        end
        StP9: if (mdone) begin
          ma_q     <= mprod;
          mb_q     <= 32'd3038;
          mstart_q <= 1'b1;
          state_q  <= StP10;
        end
        StP10: if (mdone) begin
          r0_q     <= asr(mprod, 5'd16);
          ma_q     <= r3_q;
          mb_q     <= 32'd0 - 32'd7357;
          mstart_q <= 1'b1;
          state_q  <= StP11;
        end
        StP11: if (mdone) begin
          r2_q    <= asr(mprod, 5'd16);
          state_q <= StP12;
        end
        StP12: begin
          r4_q    <= r_tmp;
          state_q <= StP13;
        end
        StP13: begin
          res_q.kind               <= bsc_pkg::CmdPress;
          res_q.temperature_tenths <= '0;
          res_q.divide_error       <= 1'b0;
          if (r4_q[31]) begin
            res_q.pressure_pa <= '0;
          end else if (r4_q > 32'd262143) begin
            res_q.pressure_pa <= 18'h3FFFF;
          end else begin
            res_q.pressure_pa <= r4_q[17:0];
          end
          state_q <= StP14;
        end
        StP14: state_q <= StP15;
        StP15: state_q <= StPDone;
        StTDone, StPDone, StOut: begin
          if (load_out) begin
            obuf_q  <= res_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/core/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the channels of the compensation block for ordering slips.
// ----------------------------------------------------------------------------
module bsc_port_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_ready_i
);

  a_cfg_only_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i |-> (in_ready_i && !out_valid_i))
    else $error("configuration taken while busy");

  a_no_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> !out_valid_i)
    else $error("result too early");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i && !cfg_ready_i)
    else $error("accepted twice");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");

endmodule

bind baro_sensor_compensation bsc_port_props u_bsc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_req.valid), .in_ready_i(in_req.ready),
  .out_valid_i(out_req.valid), .out_ready_i(out_req.ready),
  .cfg_ready_i(cfg.ready)
);
